// ===== sv/sbfn_pkg.sv =====
// Shared types and constants for the frame node.
`timescale 1ns / 1ps
package sbfn_pkg;

	localparam int ID_W    = 5;
	localparam int CMD_W   = 2;
	localparam int ANGLE_W = 21;
	localparam int BYTE_W  = 8;
	localparam int LOW7_W  = 7;

	localparam logic [ID_W-1:0] ID_RESET = 5'd31;

	// Commands that ask for a reply
	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NEIGHBOR = 2'd2;

	// Input item kinds on tuser
	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_ANGLE = 1'b1;

	// Receive parser phases
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_D0   = 2'd1;
	localparam logic [1:0] PH_D1   = 2'd2;
	localparam logic [1:0] PH_D2   = 2'd3;

	// Reply byte positions
	localparam logic [1:0] BYTE_HDR = 2'd0;
	localparam logic [1:0] BYTE_A0  = 2'd1;
	localparam logic [1:0] BYTE_A1  = 2'd2;
	localparam logic [1:0] BYTE_A2  = 2'd3;

	// One pending reply: received command and the angle held at frame end
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ANGLE_W-1:0] angle;
	} reply_t;

endpackage

// ===== sv/sbfn_front.sv =====
// Receive side: parses bus bytes, holds the angle, queues replies.
`timescale 1ns / 1ps
module sbfn_front
	import sbfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // rx_byte[7:0], angle_sample[28:8], zero[31:29]
	input  logic              s_tuser,   // mode
	input  logic [ID_W-1:0]   node_id,
	input  logic              q_full,
	output logic              q_push,
	output reply_t            q_wdata
);

	logic                 accept;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 flag;
	logic [1:0]           phase_q;
	logic [LOW7_W-1:0]    hdr_q;
	logic [ANGLE_W-1:0]   angle_q;
	logic [ID_W-1:0]      hdr_id;
	logic [CMD_W-1:0]     hdr_cmd;
	logic [ID_W-1:0]      prev_id;
	logic                 match;
	logic                 is_byte;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign rx_byte  = s_tdata[BYTE_W-1:0];
	assign flag     = rx_byte[BYTE_W-1];
	assign is_byte  = (s_tuser == MODE_BYTE);

	assign hdr_id  = hdr_q[LOW7_W-1:CMD_W];
	assign hdr_cmd = hdr_q[CMD_W-1:0];
	assign prev_id = node_id - ID_W'(1);
	assign match   = ((hdr_id == node_id) && (hdr_cmd == CMD_QUERY)) ||
	                 ((hdr_id == prev_id) && (hdr_id != node_id) && (hdr_cmd == CMD_NEIGHBOR));

	assign q_push        = accept && is_byte && (phase_q == PH_D2) && !flag && match;
	assign q_wdata.cmd   = hdr_cmd;
	assign q_wdata.angle = angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			angle_q <= '0;
		end else if (accept) begin
			if (!is_byte) begin
				angle_q <= s_tdata[BYTE_W +: ANGLE_W];
			end else begin
				case (phase_q)
					PH_WAIT: begin
						if (flag) phase_q <= PH_D0;
					end
					PH_D0: begin
						phase_q <= flag ? PH_WAIT : PH_D1;
					end
					PH_D1: begin
						phase_q <= flag ? PH_WAIT : PH_D2;
					end
					default: begin
						phase_q <= PH_WAIT;
					end
				endcase
			end
		end
	end

	// Latch the header bits on a header seen while waiting
	always_ff @(posedge clk) begin
		if (accept && is_byte && (phase_q == PH_WAIT) && flag) begin
			hdr_q <= rx_byte[LOW7_W-1:0];
		end
	end

endmodule

// ===== sv/sbfn_queue.sv =====
// Small reply queue between the receive and transmit sides.
`timescale 1ns / 1ps
module sbfn_queue
	import sbfn_pkg::*;
#(
	parameter int Q_DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  reply_t wdata,
	input  logic   pop,
	output reply_t rdata,
	output logic   empty,
	output logic   full
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	reply_t          mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(Q_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("reply pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("reply popped from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Q_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== sv/sbfn_back.sv =====
// Transmit side: turns a queued reply into four output bytes.
`timescale 1ns / 1ps
module sbfn_back
	import sbfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   node_id,
	input  reply_t            q_rdata,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // tx_byte
	output logic              m_tlast    // last_byte
);

	logic              load;
	logic [1:0]        idx_q;
	logic [BYTE_W-1:0] next_byte;
	logic              m_tvalid_q;
	logic [BYTE_W-1:0] m_tdata_q;
	logic              m_tlast_q;

	assign load  = !q_empty && (!m_tvalid_q || m_tready);
	assign q_pop = load && (idx_q == BYTE_A2);

	always_comb begin
		case (idx_q)
			BYTE_HDR: next_byte = {1'b1, node_id, q_rdata.cmd};
			BYTE_A0:  next_byte = {1'b0, q_rdata.angle[6:0]};
			BYTE_A1:  next_byte = {1'b0, q_rdata.angle[13:7]};
			BYTE_A2:  next_byte = {1'b0, q_rdata.angle[20:14]};
			default:  next_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= BYTE_HDR;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= next_byte;
			m_tlast_q <= (idx_q == BYTE_A2);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_hdr_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load && (idx_q == BYTE_HDR) |=> m_tvalid && m_tdata[BYTE_W-1] && !m_tlast)
		else $error("reply header byte malformed");

endmodule

// ===== sv/sync_bit_frame_node.sv =====
// Top level of the bus frame node.
// Reply path: with the transmit side idle, the last frame byte puts a reply in the queue, whose
// header byte is then registered out; later bytes come one per cycle while m_tready is high.
// Throughput: one input transaction per cycle; s_tready drops only while the reply
// queue holds Q_DEPTH replies waiting for the transmit side.
// Reset (arst_n low): parser waits for a header, angle is zero, node_id is 31, queue empty.
`timescale 1ns / 1ps
module sync_bit_frame_node
	import sbfn_pkg::*;
#(
	parameter int Q_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,  // node_id
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // rx_byte[7:0], angle_sample[28:8], zero[31:29]
	input  logic        s_tuser,    // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // tx_byte[7:0]
	output logic        m_tlast     // last_byte
);

	logic [ID_W-1:0] node_id_q;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;
	logic            q_full;
	reply_t          q_wdata;
	reply_t          q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= ID_RESET;
		end else if (cfg_we) begin
			node_id_q <= cfg_wdata;
		end
	end

	sbfn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.node_id  (node_id_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	sbfn_queue #(
		.Q_DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	sbfn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.node_id  (node_id_q),
		.q_rdata  (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
